>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/arus_pkg.sv
// Package for the adaptive rate update scheduler: widths, codes, constants.
// No dependencies; used by arus_div and adaptive_rate_update_scheduler.
package arus_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int NUM_WEIGHTS  = 6;
	localparam int WT_IDX_W     = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int WEIGHT_W   = 8;
	localparam int WATER_W    = 20;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER  = 3'd7;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_WEIGHTS] =
		'{8'd67, 8'd23, 8'd66, 8'd55, 8'd55, 8'd2};
	localparam logic [WATER_W-1:0] HIGH_WATER_RESET = 20'h30000;
	localparam logic [WATER_W-1:0] LOW_WATER_RESET  = 20'h10000;

	// command codes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// datapath widths
	localparam int LEVEL_W = 16;
	localparam int SUM_W   = 21;
	localparam int CNT_W   = 5;
	localparam int RATE_W  = 12;
	localparam int PHASE_W = 16;
	localparam int NEXT_W  = 18;
	localparam int INC_W   = 17;
	localparam int DUE_W   = 6;
	localparam int PROD_W  = WEIGHT_W + RATE_W;
	localparam int QUO_W   = 13;

	localparam logic [CNT_W-1:0]   SAMPLE_WIN = 5'd16;
	localparam logic [RATE_W-1:0]  RATE_RESET = 12'd64;
	localparam logic [RATE_W-1:0]  RATE_MIN   = 12'd8;
	localparam logic [RATE_W-1:0]  RATE_MAX   = 12'd2048;
	localparam logic [PHASE_W-1:0] PHASE_STEP = 16'h0100;
	localparam logic [INC_W-1:0]   STEP_DIVIDEND = 17'h10000;

	// x / 100 == (x * 671089) >> 26 for every x below 2**20
	localparam logic [PROD_W-1:0] DIV100_MUL   = 20'd671089;
	localparam int                DIV100_SHIFT = 26;

	localparam logic [QUO_W-1:0] DVS_FLOOR     = 13'd1;
	localparam logic [QUO_W-1:0] DVS_RANGE_MIN = 13'd2;
	localparam logic [QUO_W-1:0] DVS_RANGE_MAX = 13'd256;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/arus_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on arus_pkg (div_stat_t, default widths) and assert_macros.svh.
`include "assert_macros.svh"

module arus_div #(
	parameter int DVD_W = arus_pkg::INC_W,
	parameter int DVS_W = arus_pkg::QUO_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_W-1:0]    dividend,
	input  logic [DVS_W-1:0]    divisor,
	output arus_pkg::div_stat_t stat,
	output logic [DVD_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0] r_sh;
	logic [DVS_W:0] r_sub;
	logic           ge;

	assign r_sh  = {rem_q, acc_q[DVD_W-1]};
	assign ge    = r_sh >= {1'b0, dvs_q};
	assign r_sub = r_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_W-2:0], ge};
			rem_q <= ge ? r_sub[DVS_W-1:0] : r_sh[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = acc_q;

	`ASSERT_ALWAYS(a_no_restart, clk, arst_n, !(start && busy_q), "divider restarted while busy")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q && !busy_q, "done not a single pulse")

endmodule

>>> hw/rtl/adaptive_rate_update_scheduler.sv
// Adaptive rate update scheduler, top level. Depends on arus_pkg, arus_div.
// Tick and unused mode go straight to the result word; a plain sample first
// checks its window; init and an adapting sample recompute each channel's step
// in turn through the shared 17-bit divider. One word in flight: in_ready is low
// until the result is in the out register. Reset (arst_n low) restores register
// defaults and clears the scheduling state, the adjust factor returning to 64.
`include "assert_macros.svh"

module adaptive_rate_update_scheduler #(
	parameter int NUM_CHANNELS = arus_pkg::NUM_CHANNELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [arus_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arus_pkg::CFG_DATA_W-1:0]     cfg_data,
	// command word in
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [arus_pkg::MODE_W-1:0]         mode,
	input  logic [arus_pkg::LEVEL_W-1:0]        queue_level,
	// result word out
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [arus_pkg::DUE_W-1:0]          due_mask,
	output logic [arus_pkg::RATE_W-1:0]         adjust_factor
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	// sequencer states
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_IDLE     = 3'd0;
	localparam logic [ST_W-1:0] S_ADAPT    = 3'd1;
	localparam logic [ST_W-1:0] S_MUL      = 3'd2;
	localparam logic [ST_W-1:0] S_SCALE    = 3'd3;
	localparam logic [ST_W-1:0] S_DIVSTART = 3'd4;
	localparam logic [ST_W-1:0] S_DIVWAIT  = 3'd5;
	localparam logic [ST_W-1:0] S_DONE     = 3'd6;

	// config registers
	logic [arus_pkg::WEIGHT_W-1:0] wt_q [arus_pkg::NUM_WEIGHTS];
	logic [arus_pkg::WATER_W-1:0]  high_q;
	logic [arus_pkg::WATER_W-1:0]  low_q;

	// scheduling state
	logic [ST_W-1:0]                state_q;
	logic [CH_W-1:0]                ch_q;
	logic                           range_clamp_q; // 1: divisor 2..256, 0: floor of 1
	logic                           set_next_q;    // init also loads next-due times
	logic [arus_pkg::PHASE_W-1:0]   phase_q;
	logic [arus_pkg::NEXT_W-1:0]    nd_q  [NUM_CHANNELS];
	logic [arus_pkg::INC_W-1:0]     inc_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]        flags_q;
	logic [arus_pkg::SUM_W-1:0]     sum_q;
	logic [arus_pkg::CNT_W-1:0]     cnt_q;
	logic [arus_pkg::RATE_W-1:0]    rate_q;

	// per-channel step pipeline
	logic [arus_pkg::PROD_W-1:0]    prod_s1;
	logic [arus_pkg::QUO_W-1:0]     quo100_s2;

	// output register
	logic                           out_valid_q;
	logic [arus_pkg::DUE_W-1:0]     due_q;
	logic [arus_pkg::RATE_W-1:0]    adj_q;

	logic in_acc;
	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// ---------------- weight of the channel in work ----------------
	logic [arus_pkg::WT_IDX_W-1:0]  wt_idx;
	logic [arus_pkg::WEIGHT_W-1:0]  ch_weight;
	assign wt_idx = arus_pkg::WT_IDX_W'(ch_q);
	always_comb begin
		ch_weight = '0;
		if (wt_idx < arus_pkg::WT_IDX_W'(arus_pkg::NUM_WEIGHTS))
			ch_weight = wt_q[wt_idx];
	end

	// divide by 100 as a reciprocal multiply
	logic [2*arus_pkg::PROD_W-1:0] scaled;
	assign scaled = (2*arus_pkg::PROD_W)'(prod_s1) *
		(2*arus_pkg::PROD_W)'(arus_pkg::DIV100_MUL);

	// divisor clamp ahead of the divider
	logic [arus_pkg::QUO_W-1:0] dvs;
	always_comb begin
		dvs = quo100_s2;
		if (range_clamp_q) begin
			if (quo100_s2 > arus_pkg::DVS_RANGE_MAX)
				dvs = arus_pkg::DVS_RANGE_MAX;
			else if (quo100_s2 < arus_pkg::DVS_RANGE_MIN)
				dvs = arus_pkg::DVS_RANGE_MIN;
		end else if (quo100_s2 == '0) begin
			dvs = arus_pkg::DVS_FLOOR;
		end
	end

	// ---------------- shared divider ----------------
	logic                        div_start;
	arus_pkg::div_stat_t         div_stat;
	logic [arus_pkg::INC_W-1:0]  div_quo;
	assign div_start = (state_q == S_DIVSTART);

	arus_div #(
		.DVD_W (arus_pkg::INC_W),
		.DVS_W (arus_pkg::QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (arus_pkg::STEP_DIVIDEND),
		.divisor  (dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ---------------- sample: leaky sum ----------------
	logic                        win_full;
	logic [arus_pkg::SUM_W-1:0]  sum_leak;
	logic [arus_pkg::SUM_W-1:0]  sum_nx;
	assign win_full = (cnt_q >= arus_pkg::SAMPLE_WIN);
	assign sum_leak = win_full ? sum_q - (sum_q >> 4) : sum_q;
	assign sum_nx   = sum_leak + arus_pkg::SUM_W'(queue_level);

	// rate steps
	logic [arus_pkg::RATE_W-1:0] rate_dn_raw;
	logic [arus_pkg::RATE_W-1:0] rate_dn;
	logic [arus_pkg::RATE_W-1:0] rate_up;
	assign rate_dn_raw = rate_q - (rate_q >> 4);
	assign rate_dn = (rate_dn_raw < arus_pkg::RATE_MIN) ? arus_pkg::RATE_MIN : rate_dn_raw;
	assign rate_up = (rate_q >= arus_pkg::RATE_MAX) ? arus_pkg::RATE_MAX : rate_q + 1'b1;

	// ---------------- tick: all channels side by side ----------------
	logic [arus_pkg::PHASE_W-1:0] phase_nx;
	logic [arus_pkg::NEXT_W-1:0]  tick_nd   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]      tick_hit;
	assign phase_nx = phase_q + arus_pkg::PHASE_STEP;

	always_comb begin
		logic [arus_pkg::NEXT_W-1:0] base;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			// on phase wrap every channel restarts from its step
			base = (phase_nx == '0) ? arus_pkg::NEXT_W'(inc_q[c]) : nd_q[c];
			tick_hit[c] = base < arus_pkg::NEXT_W'(phase_nx);
			tick_nd[c]  = tick_hit[c] ? base + arus_pkg::NEXT_W'(inc_q[c]) : base;
		end
	end

	// ---------------- config registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < arus_pkg::NUM_WEIGHTS; i++)
				wt_q[i] <= arus_pkg::WEIGHT_RESET[i];
			high_q <= arus_pkg::HIGH_WATER_RESET;
			low_q  <= arus_pkg::LOW_WATER_RESET;
		end else if (cfg_we) begin
			for (int i = 0; i < arus_pkg::NUM_WEIGHTS; i++)
				if (cfg_index == arus_pkg::CFG_IDX_W'(i))
					wt_q[i] <= cfg_data[arus_pkg::WEIGHT_W-1:0];
			if (cfg_index == arus_pkg::REG_HIGH_WATER)
				high_q <= cfg_data[arus_pkg::WATER_W-1:0];
			if (cfg_index == arus_pkg::REG_LOW_WATER)
				low_q <= cfg_data[arus_pkg::WATER_W-1:0];
		end
	end

	// ---------------- sequencer and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ch_q          <= '0;
			range_clamp_q <= 1'b0;
			set_next_q    <= 1'b0;
			phase_q       <= '0;
			flags_q       <= '0;
			sum_q         <= '0;
			cnt_q         <= '0;
			rate_q        <= arus_pkg::RATE_RESET;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				nd_q[c]  <= '0;
				inc_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ch_q <= '0;
						priority if (mode == arus_pkg::MODE_INIT) begin
							sum_q         <= '0;
							cnt_q         <= '0;
							phase_q       <= '0;
							flags_q       <= '0;
							rate_q        <= arus_pkg::RATE_RESET;
							range_clamp_q <= 1'b0;
							set_next_q    <= 1'b1;
							state_q       <= S_MUL;
						end else if (mode == arus_pkg::MODE_SAMPLE) begin
							sum_q   <= sum_nx;
							if (!win_full)
								cnt_q <= cnt_q + 1'b1;
							state_q <= S_ADAPT;
						end else if (mode == arus_pkg::MODE_TICK) begin
							phase_q <= phase_nx;
							flags_q <= tick_hit;
							for (int c = 0; c < NUM_CHANNELS; c++)
								nd_q[c] <= tick_nd[c];
							state_q <= S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ADAPT: begin
					// adapt only once the window holds 16 samples
					set_next_q <= 1'b0;
					if (cnt_q < arus_pkg::SAMPLE_WIN) begin
						state_q <= S_DONE;
					end else if (sum_q > arus_pkg::SUM_W'(high_q)) begin
						rate_q        <= rate_dn;
						range_clamp_q <= 1'b0;
						state_q       <= S_MUL;
					end else if (sum_q < arus_pkg::SUM_W'(low_q)) begin
						rate_q        <= rate_up;
						range_clamp_q <= 1'b1;
						state_q       <= S_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_DIVSTART;
				end
				S_DIVSTART: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_stat.done) begin
						inc_q[ch_q] <= div_quo;
						if (set_next_q)
							nd_q[ch_q] <= arus_pkg::NEXT_W'(div_quo);
						if (ch_q == CH_LAST) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output valid: set as a word is loaded, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// step pipeline registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_MUL)
			prod_s1 <= arus_pkg::PROD_W'(ch_weight) * arus_pkg::PROD_W'(rate_q);
		if (state_q == S_SCALE)
			quo100_s2 <= scaled[arus_pkg::DIV100_SHIFT +: arus_pkg::QUO_W];
	end

	// result word payload
	logic [arus_pkg::DUE_W-1:0] mask_now;
	for (genvar i = 0; i < arus_pkg::DUE_W; i++) begin : g_mask
		if (i < NUM_CHANNELS) begin : g_live
			assign mask_now[i] = flags_q[i];
		end else begin : g_pad
			assign mask_now[i] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			due_q <= mask_now;
			adj_q <= rate_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign due_mask      = due_q;
	assign adjust_factor = adj_q;

	`ASSERT_ALWAYS(a_rate_range, clk, arst_n, rate_q >= arus_pkg::RATE_MIN && rate_q <= arus_pkg::RATE_MAX, "adjust factor out of range")
	`ASSERT_ALWAYS(a_cnt_sat, clk, arst_n, cnt_q <= arus_pkg::SAMPLE_WIN, "sample count past window")
	`ASSERT_NEXT(a_div_follow, clk, arst_n, state_q == S_DIVSTART, div_stat.busy && state_q == S_DIVWAIT, "divider did not start")
	`ASSERT_ALWAYS(a_busy_in_wait, clk, arst_n, !div_stat.busy || state_q == S_DIVWAIT, "divider busy outside wait state")

endmodule

>>> verif/adaptive_rate_update_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for adaptive_rate_update_scheduler: random stalls, scoreboard.
// Depends on arus_pkg and the scheduler RTL; needs no other file.

module adaptive_rate_update_scheduler_tb;
	import arus_pkg::*;

	// the block defines no code for mode 3; it must leave the state alone
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 3'd0;

	localparam int unsigned PCT_SCALE  = 100;  // weights are percentages
	localparam int          SUM_SHIFT  = 4;    // leak of the 16-sample sum
	localparam int          RATE_SHIFT = 4;    // throttle step is 1/16 of the factor

	localparam logic [WATER_W-1:0] WATER_MAX = '1;

	// Block is idle once its last word is out; quiesce adds a settle margin before a
	// register write. The tail wait covers even the longest operation.
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES    = 200;
	// ~1650 words, each at worst the longest sender gap, the divider work and the
	// longest receiver stall, then taken a few times over.
	localparam longint unsigned CYCLE_LIMIT = 5_000_000;

	typedef struct packed {
		logic [DUE_W-1:0]  due;
		logic [RATE_W-1:0] rate;
	} sched_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [MODE_W-1:0]     mode;
	logic [LEVEL_W-1:0]    queue_level;
	logic                  out_valid;
	logic                  out_ready;
	logic [DUE_W-1:0]      due_mask;
	logic [RATE_W-1:0]     adjust_factor;

	adaptive_rate_update_scheduler DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.mode,
		.queue_level,
		.out_valid,
		.out_ready,
		.due_mask,
		.adjust_factor
	);

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the registers and of the schedule
	// ------------------------------------------------------------------
	logic [WEIGHT_W-1:0] weight_cfg [NUM_WEIGHTS];
	logic [WATER_W-1:0]  high_water_cfg;
	logic [WATER_W-1:0]  low_water_cfg;

	logic [PHASE_W-1:0]  sch_phase;
	logic [NEXT_W-1:0]   sch_next [NUM_CHANNELS];
	logic [INC_W-1:0]    sch_incr [NUM_CHANNELS];
	logic [DUE_W-1:0]    sch_due;
	logic [SUM_W-1:0]    sch_level_sum;
	logic [CNT_W-1:0]    sch_samples;
	logic [RATE_W-1:0]   sch_rate;

	// words predicted at accept, popped as results come out
	sched_word_t sched_expect_q [$];

	// knobs for idling; tests flip them to get stretches with and without gaps
	bit sender_idles;
	bit receiver_stalls;

	int fail_count;
	int mode_count [4];
	int throttle_count;
	int boost_count;
	int wrap_count;
	int peak_rate;
	longint unsigned cycle_count;

	// weight * factor / 100, truncated; channels past the weight registers get 0
	function automatic int unsigned chan_divisor(input int c);
		int unsigned prod;
		prod = (c < NUM_WEIGHTS) ? weight_cfg[c] : 0;
		prod = prod * sch_rate;
		return prod / PCT_SCALE;
	endfunction

	function automatic logic [INC_W-1:0] step_for(input int unsigned dvs);
		int unsigned quo;
		quo = STEP_DIVIDEND / dvs;
		return quo[INC_W-1:0];
	endfunction

	// Recompute every step; ranged selects the 2..256 clamp used when speeding
	// up, otherwise the divisor only has a floor of 1.
	function automatic void refresh_steps(input logic ranged);
		int unsigned dvs;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			dvs = chan_divisor(c);
			if (ranged) begin
				if (dvs > DVS_RANGE_MAX)
					dvs = DVS_RANGE_MAX;
				if (dvs < DVS_RANGE_MIN)
					dvs = DVS_RANGE_MIN;
			end else if (dvs == 0) begin
				dvs = DVS_FLOOR;
			end
			sch_incr[c] = step_for(dvs);
		end
	endfunction

	// Advance the predicted schedule by one command word and return the
	// result word the block must produce for it.
	function automatic sched_word_t schedule_step(input logic [MODE_W-1:0] m,
			input logic [LEVEL_W-1:0] lvl);
		sched_word_t w;
		case (m)
			MODE_INIT: begin
				sch_level_sum = '0;
				sch_samples   = '0;
				sch_phase     = '0;
				sch_due       = '0;
				sch_rate      = RATE_RESET;
				refresh_steps(1'b0);
				for (int c = 0; c < NUM_CHANNELS; c++)
					sch_next[c] = NEXT_W'(sch_incr[c]);
			end
			MODE_SAMPLE: begin
				if (sch_samples >= SAMPLE_WIN)
					sch_level_sum = sch_level_sum - (sch_level_sum >> SUM_SHIFT);
				else
					sch_samples = sch_samples + 1'b1;
				sch_level_sum = sch_level_sum + SUM_W'(lvl);
				// adapt only with a full window
				if (sch_samples == SAMPLE_WIN) begin
					if (sch_level_sum > high_water_cfg) begin
						sch_rate = sch_rate - (sch_rate >> RATE_SHIFT);
						if (sch_rate < RATE_MIN)
							sch_rate = RATE_MIN;
						refresh_steps(1'b0);
						throttle_count++;
					end else if (sch_level_sum < low_water_cfg) begin
						if (sch_rate < RATE_MAX)
							sch_rate = sch_rate + 1'b1;
						refresh_steps(1'b1);
						boost_count++;
					end
				end
			end
			MODE_TICK: begin
				sch_phase = sch_phase + PHASE_STEP;
				if (sch_phase == 0) begin
					wrap_count++;
					for (int c = 0; c < NUM_CHANNELS; c++)
						sch_next[c] = NEXT_W'(sch_incr[c]);
				end
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (sch_next[c] < sch_phase) begin
						sch_due[c]  = 1'b1;
						sch_next[c] = sch_next[c] + NEXT_W'(sch_incr[c]);
					end else begin
						sch_due[c] = 1'b0;
					end
				end
			end
			default: ;  // spare code: report state untouched
		endcase
		if (int'(sch_rate) > peak_rate)
			peak_rate = int'(sch_rate);
		w.due  = sch_due;
		w.rate = sch_rate;
		return w;
	endfunction

	// mostly no idling, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 160);
	endfunction

	// ------------------------------------------------------------------
	// Clock, result check, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: out_ready changes on the falling edge, in random bursts.
	initial begin
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && receiver_stalls && $urandom_range(0, 19) == 0)
				stall = idle_len();
			out_ready <= (stall == 0);
			if (stall > 0)
				stall--;
		end
	end

	// Each result word is matched against the oldest prediction.
	always @(posedge clk) begin
		sched_word_t exp_word;
		if (arst_n && out_valid && out_ready) begin
			if (sched_expect_q.size() == 0) begin
				$error("result word with nothing predicted: due_mask %0h adjust_factor %0d",
					due_mask, adjust_factor);
				fail_count++;
			end else begin
				exp_word = sched_expect_q.pop_front();
				if (due_mask !== exp_word.due) begin
					$error("due_mask: expected %0h, got %0h", exp_word.due, due_mask);
					fail_count++;
				end
				if (adjust_factor !== exp_word.rate) begin
					$error("adjust_factor: expected %0d, got %0d", exp_word.rate,
						adjust_factor);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d words still owed",
				cycle_count, sched_expect_q.size());
			$display("adaptive_rate_update_scheduler_tb failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One command word: optional gap, then hold valid until the handshake.
	// Valid is left high on return so back-to-back words keep it asserted.
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [LEVEL_W-1:0] lvl);
		int gap;
		gap = sender_idles ? idle_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		queue_level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sched_expect_q.push_back(schedule_step(m, lvl));
		mode_count[m]++;
	endtask

	// sender holds off until every predicted word has been checked
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sched_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// drained plus margin: safe point for register writes
	task automatic quiesce();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HIGH_WATER)
			high_water_cfg = val[WATER_W-1:0];
		else if (idx == REG_LOW_WATER)
			low_water_cfg = val[WATER_W-1:0];
		else if (idx < NUM_WEIGHTS)
			weight_cfg[idx] = val[WEIGHT_W-1:0];
	endtask

	// junk in the upper data bits: only the low byte belongs to a weight
	task automatic write_weight(input int c, input logic [WEIGHT_W-1:0] w);
		logic [CFG_DATA_W-1:0] val;
		val = CFG_DATA_W'($urandom);
		val[WEIGHT_W-1:0] = w;
		cfg_write(REG_WEIGHT0 + CFG_IDX_W'(c), val);
	endtask

	// random weights biased to the edges, caller picks the water marks
	task automatic load_random_config(input logic [WATER_W-1:0] hw,
			input logic [WATER_W-1:0] lw);
		int r;
		for (int c = 0; c < NUM_WEIGHTS; c++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				write_weight(c, '0);
			else if (r < 30)
				write_weight(c, '1);
			else if (r < 40)
				write_weight(c, 8'd1);
			else
				write_weight(c, WEIGHT_W'($urandom_range(0, 255)));
		end
		cfg_write(REG_HIGH_WATER, hw);
		cfg_write(REG_LOW_WATER, lw);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Straight out of reset: steps are zero, so every channel fires on every
	// tick; samples and the spare code before any init; then init on defaults.
	task automatic test_before_init();
		send_word(MODE_TICK, '0);
		send_word(MODE_TICK, '1);
		send_word(MODE_SPARE, 16'h5A5A);
		send_word(MODE_SAMPLE, '1);
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_TICK, 16'hA5A5);
		send_word(MODE_INIT, '1);
		send_word(MODE_TICK, '0);
	endtask

	// Zero weight forces the divisor floor (step 65536), 255 the shortest step.
	task automatic test_weight_extremes();
		quiesce();
		write_weight(0, '0);
		write_weight(1, '1);
		write_weight(2, 8'd1);
		write_weight(3, 8'd254);
		write_weight(4, 8'd128);
		write_weight(5, 8'd2);
		send_word(MODE_INIT, 16'h0F0F);
		for (int i = 0; i < 4; i++)
			send_word(MODE_TICK, LEVEL_W'($urandom));
		send_word(MODE_SPARE, '1);
		send_word(MODE_SAMPLE, '1);
	endtask

	// High water at 0: every full-window sample throttles the factor down to
	// where its 1/16 step becomes zero.
	task automatic test_throttle();
		quiesce();
		load_random_config('0, '0);
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		send_word(MODE_INIT, '0);
		for (int i = 0; i < 60; i++) begin
			if (i == 30)
				drain_results();
			if (i % 5 == 4)
				send_word(MODE_TICK, LEVEL_W'($urandom));
			else
				send_word(MODE_SAMPLE, LEVEL_W'($urandom_range(1, 65535)));
		end
	endtask

	// Marks at the extremes of the range: the sum sits inside the band, no change.
	task automatic test_band_hold();
		quiesce();
		load_random_config(WATER_MAX, '0);
		send_word(MODE_INIT, LEVEL_W'($urandom));
		for (int i = 0; i < 24; i++) begin
			if (i % 6 == 5)
				send_word(MODE_TICK, LEVEL_W'($urandom));
			else
				send_word(MODE_SAMPLE, LEVEL_W'($urandom));
		end
	endtask

	// Low water at max: factor climbs by one per full-window sample toward the
	// 2048 cap, with ticks mixed in so the phase wraps and the 2..256 clamp is seen.
	task automatic test_rate_cap();
		int extra;
		int n;
		quiesce();
		load_random_config(WATER_MAX, WATER_MAX);
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		send_word(MODE_INIT, LEVEL_W'($urandom));
		extra = 0;
		n     = 0;
		while (extra < 12 && n < 940) begin
			// first stretch runs with no idling at all
			if (n == 500) begin
				sender_idles    = 1'b1;
				receiver_stalls = 1'b1;
			end
			if ($urandom_range(0, 2) == 0)
				send_word(MODE_TICK, LEVEL_W'($urandom));
			else
				send_word(MODE_SAMPLE, LEVEL_W'($urandom));
			if (sch_rate == RATE_MAX)
				extra++;
			n++;
		end
	endtask

	// Random settings per phase; well-formed init-then-traffic sequences with
	// stray inits, spare codes and level extremes thrown in.
	task automatic test_random_mix();
		logic [WATER_W-1:0]  hw;
		logic [WATER_W-1:0]  lw;
		logic [LEVEL_W-1:0]  lvl_lo;
		logic [LEVEL_W-1:0]  lvl_hi;
		int r;
		for (int ph = 0; ph < 5; ph++) begin
			quiesce();
			case ($urandom_range(0, 3))
				0: begin
					hw = WATER_W'($urandom_range(0, 20'h3FFFF));
					lw = WATER_W'($urandom_range(0, hw));
				end
				1: begin
					hw = WATER_MAX;
					lw = WATER_W'($urandom_range(20'h80000, WATER_MAX));
				end
				2: begin
					hw = WATER_W'($urandom);
					lw = WATER_W'($urandom);  // may land above high water
				end
				default: begin
					hw = '0;
					lw = WATER_MAX;
				end
			endcase
			load_random_config(hw, lw);
			lvl_lo          = LEVEL_W'($urandom);
			lvl_hi          = LEVEL_W'($urandom_range(lvl_lo, 65535));
			sender_idles    = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			send_word(MODE_INIT, LEVEL_W'($urandom));
			for (int i = 0; i < 120; i++) begin
				if ($urandom_range(0, 49) == 0)
					drain_results();
				r = $urandom_range(0, 99);
				if (r < 48)
					send_word(MODE_TICK, LEVEL_W'($urandom));
				else if (r < 88)
					send_word(MODE_SAMPLE, LEVEL_W'($urandom_range(lvl_lo, lvl_hi)));
				else if (r < 93)
					send_word(MODE_INIT, LEVEL_W'($urandom));
				else if (r < 97)
					send_word(MODE_SPARE, LEVEL_W'($urandom));
				else
					send_word(MODE_SAMPLE, $urandom_range(0, 1) ? '1 : '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		mode        = MODE_INIT;
		queue_level = '0;

		// predictor starts where reset leaves the block
		for (int c = 0; c < NUM_WEIGHTS; c++)
			weight_cfg[c] = WEIGHT_RESET[c];
		high_water_cfg = HIGH_WATER_RESET;
		low_water_cfg  = LOW_WATER_RESET;
		sch_phase      = '0;
		sch_due        = '0;
		sch_level_sum  = '0;
		sch_samples    = '0;
		sch_rate       = RATE_RESET;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			sch_next[c] = '0;
			sch_incr[c] = '0;
		end
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		fail_count      = 0;
		throttle_count  = 0;
		boost_count     = 0;
		wrap_count      = 0;
		peak_rate       = 0;
		cycle_count     = 0;
		for (int k = 0; k < 4; k++)
			mode_count[k] = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_before_init();
		test_weight_extremes();
		test_throttle();
		test_band_hold();
		test_rate_cap();
		test_random_mix();

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (sched_expect_q.size() != 0) begin
			$error("%0d predicted words never came out", sched_expect_q.size());
			fail_count++;
		end

		$display("Sent %0d init, %0d sample, %0d tick, %0d spare-code words in %0d cycles.",
			mode_count[MODE_INIT], mode_count[MODE_SAMPLE], mode_count[MODE_TICK],
			mode_count[MODE_SPARE], cycle_count);
		$display("Factor cut %0d times, raised %0d times (peak %0d), phase wrapped %0d times.",
			throttle_count, boost_count, peak_rate, wrap_count);
		if (fail_count == 0)
			$display("adaptive_rate_update_scheduler_tb passed");
		else
			$display("adaptive_rate_update_scheduler_tb failed");
		$finish;
	end

endmodule
